### rtl/dvi_line_sequencer_audio_pacer_core_assert.svh
// Assertion macros for the checker file of the line sequencer.
`ifndef DVI_LINE_SEQUENCER_AUDIO_PACER_CORE_ASSERT_SVH
`define DVI_LINE_SEQUENCER_AUDIO_PACER_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define DLSAP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define DLSAP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/dlsap_pkg.sv
// Types and constants of the line sequencer and audio pacer.
package dlsap_pkg;

   // Vertical phase codes.
   localparam logic [1:0] PH_FRONT  = 2'd0;
   localparam logic [1:0] PH_SYNC   = 2'd1;
   localparam logic [1:0] PH_BACK   = 2'd2;
   localparam logic [1:0] PH_ACTIVE = 2'd3;

   // Data island packet kinds.
   localparam logic [2:0] PKT_NULL     = 3'd0;
   localparam logic [2:0] PKT_AVI      = 3'd1;
   localparam logic [2:0] PKT_AUDIO_IF = 3'd2;
   localparam logic [2:0] PKT_CLK_REGEN = 3'd3;
   localparam logic [2:0] PKT_SAMPLES  = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_FRONT_PORCH = 3'd0;
   localparam logic [2:0] REG_SYNC        = 3'd1;
   localparam logic [2:0] REG_BACK_PORCH  = 3'd2;
   localparam logic [2:0] REG_ACTIVE      = 3'd3;
   localparam logic [2:0] REG_BLANK_TOP   = 3'd4;
   localparam logic [2:0] REG_BLANK_BOT   = 3'd5;
   localparam logic [2:0] REG_MODE        = 3'd6;
   localparam logic [2:0] REG_SPL         = 3'd7;

   // Mode bit positions.
   localparam int MODE_SCANLINE = 0;
   localparam int MODE_ISLAND   = 1;

   // Audio pacing constants.
   localparam logic [10:0] STARVE_LINES = 11'd1024;
   localparam logic [2:0]  MAX_SAMPLES  = 3'd4;
   localparam logic [23:0] POS_MAX      = 24'hFF_FFFF;

   typedef struct packed {
      logic        queue_nonempty;
      logic [9:0]  queue_head_line;
      logic [11:0] samples_available;
   } req_type;

   typedef struct packed {
      logic [1:0]  line_phase;
      logic [10:0] line_index;
      logic        blank_line;
      logic        take_buffer;
      logic        use_buffer;
      logic        release_buffer;
      logic [2:0]  packet_kind;
      logic [2:0]  sample_count;
   } rsp_type;

   typedef struct packed {
      logic [10:0] front_porch_lines;
      logic [10:0] sync_lines;
      logic [10:0] back_porch_lines;
      logic [10:0] active_lines;
      logic [10:0] blank_top;
      logic [10:0] blank_bottom;
      logic [1:0]  mode_bits;
      logic [17:0] samples_per_line_q16;
   } csr_type;

   // Sequencer view handed to the packet scheduler and the result register.
   typedef struct packed {
      logic [1:0]  phase;
      logic [10:0] line_index;
      logic        frame;
      logic        blank;
      logic        take;
      logic        use_buf;
      logic        release_buf;
   } tim_type;

endpackage

### rtl/dlsap_timing.sv
// Vertical phase sequencer, line blanking and line buffer hand-off.
module dlsap_timing #(
   parameter int LINES_PER_BUFFER = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  dlsap_pkg::csr_type csr,
   input  logic               queue_nonempty,
   input  logic [9:0]         queue_head_line,
   output dlsap_pkg::tim_type tim
);

   localparam int GRP_W = (LINES_PER_BUFFER > 1) ? $clog2(LINES_PER_BUFFER) : 1;
   localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(LINES_PER_BUFFER - 1);

   logic [1:0]       phase_ff, phase_in;
   logic [10:0]      line_ff, line_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic             frame_ff, frame_in;
   logic             hold_ff, hold_in;

   logic [10:0]      line_inc;
   logic [10:0]      phase_len;
   logic             phase_end;
   logic [GRP_W-1:0] grp_inc;
   logic signed [12:0] bottom_limit;
   logic             forced_blank;
   logic             take;
   logic             rel;

   // Length of the phase being counted.
   always_comb begin
      case (phase_ff)
         dlsap_pkg::PH_FRONT: phase_len = csr.front_porch_lines;
         dlsap_pkg::PH_SYNC:  phase_len = csr.sync_lines;
         dlsap_pkg::PH_BACK:  phase_len = csr.back_porch_lines;
         default:             phase_len = csr.active_lines;
      endcase
   end

   // Advance the line counter and the phase.
   always_comb begin
      line_inc  = line_ff + 11'd1;
      phase_end = (line_inc == phase_len);
      phase_in  = phase_end ? phase_ff + 2'd1 : phase_ff;
      line_in   = phase_end ? 11'd0 : line_inc;
   end

   // Position within the buffer group follows the line counter and restarts when it wraps to zero.
   always_comb begin
      grp_inc = (grp_ff == GRP_LAST) ? '0 : grp_ff + GRP_W'(1);
      grp_in  = (line_in == 11'd0) ? '0 : grp_inc;
   end

   // Top and bottom blanking; the bottom limit may go negative.
   always_comb begin
      bottom_limit = $signed({2'b00, csr.active_lines}) - $signed({2'b00, csr.blank_bottom});
      forced_blank = (line_in < csr.blank_top) ||
                     ($signed({2'b00, line_in}) >= bottom_limit);
   end

   // Buffer take, use and release on visible active lines.
   always_comb begin
      take    = 1'b0;
      rel     = 1'b0;
      hold_in = hold_ff;
      tim.phase      = phase_in;
      tim.line_index = line_in;
      tim.frame      = frame_ff;
      tim.blank      = 1'b0;
      tim.use_buf    = 1'b0;
      if (phase_in == dlsap_pkg::PH_ACTIVE) begin
         if (forced_blank) begin
            tim.blank = 1'b1;
         end else begin
            if (!hold_ff && queue_nonempty && ({queue_head_line, 1'b0} == line_in)) begin
               take    = 1'b1;
               hold_in = 1'b1;
            end
            tim.use_buf = hold_in;
            if (grp_in == GRP_LAST) begin
               rel     = hold_in;
               hold_in = 1'b0;
            end
            tim.blank = csr.mode_bits[dlsap_pkg::MODE_SCANLINE] & line_in[0];
         end
      end
      tim.take        = take;
      tim.release_buf = rel;
   end

   // The frame parity toggles on entry to sync.
   assign frame_in = frame_ff ^ ((phase_in != phase_ff) && (phase_in == dlsap_pkg::PH_SYNC));

   // Sequencer state moves once per transfer into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dlsap_pkg::PH_FRONT;
         line_ff  <= '0;
         grp_ff   <= '0;
         frame_ff <= 1'b0;
         hold_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         grp_ff   <= grp_in;
         frame_ff <= frame_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

### rtl/dlsap_island.sv
// Data island packet scheduler with the Q16 audio pacing accumulator.
module dlsap_island (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  dlsap_pkg::csr_type csr,
   input  dlsap_pkg::tim_type tim,
   input  logic [11:0]        samples_available,
   output logic [2:0]         packet_kind,
   output logic [2:0]         sample_count
);

   logic [10:0] starve_ff, starve_in;
   logic [23:0] pos_ff, pos_in;

   logic [24:0] pos_sum;
   logic [23:0] pos_sat;
   logic [2:0]  n_cap;
   logic [2:0]  n_take;

   // Accumulate with saturation, then limit the sample count.
   always_comb begin
      pos_sum = {1'b0, pos_ff} + {7'd0, csr.samples_per_line_q16};
      pos_sat = pos_sum[24] ? dlsap_pkg::POS_MAX : pos_sum[23:0];
      n_cap   = (pos_sat[23:16] > {5'd0, dlsap_pkg::MAX_SAMPLES}) ?
                dlsap_pkg::MAX_SAMPLES : pos_sat[18:16];
      n_take  = ({9'd0, n_cap} > samples_available) ? samples_available[2:0] : n_cap;
   end

   // Packet choice for this line.
   always_comb begin
      packet_kind  = dlsap_pkg::PKT_NULL;
      sample_count = 3'd0;
      starve_in    = starve_ff;
      pos_in       = pos_ff;
      if (csr.mode_bits[dlsap_pkg::MODE_ISLAND] && (csr.samples_per_line_q16 != 18'd0)) begin
         if (starve_ff != 11'd0) begin
            starve_in = starve_ff - 11'd1;
         end else begin
            if (samples_available == 12'd0) begin
               starve_in = dlsap_pkg::STARVE_LINES;
            end
            pos_in = pos_sat;
            if ((tim.phase == dlsap_pkg::PH_FRONT) && (tim.line_index == 11'd0)) begin
               packet_kind = tim.frame ? dlsap_pkg::PKT_AVI : dlsap_pkg::PKT_AUDIO_IF;
            end else if ((tim.phase == dlsap_pkg::PH_FRONT) && (tim.line_index == 11'd1)) begin
               packet_kind = dlsap_pkg::PKT_CLK_REGEN;
            end else begin
               pos_in = pos_sat - {5'd0, n_take, 16'd0};
               if (n_take != 3'd0) begin
                  packet_kind  = dlsap_pkg::PKT_SAMPLES;
                  sample_count = n_take;
               end
            end
         end
      end
   end

   // Audio state moves once per transfer into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         starve_ff <= '0;
         pos_ff    <= '0;
      end else if (advance) begin
         starve_ff <= starve_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

### rtl/dvi_line_sequencer_audio_pacer_core.sv
// Top level of the scanline sequencer and data island audio pacer.
//
//   Channel  Ports        Direction  Moves
//   req      req_*        in         one scanline tick with queue and ring status
//   rsp      rsp_*        out        one line decision per tick
//   csr      csr_*        in         register writes, no read-back
//
// Each tick passes through two registers from input transfer to result: an input register,
// then the sequencer and packet logic in one pass into the result register.
// One tick is accepted every cycle while the result side keeps up.
// Synchronous reset restores the register defaults and clears all sequencer state.
// A stalled result holds; the input register still takes one more tick behind it.
module dvi_line_sequencer_audio_pacer_core #(
   parameter int LINES_PER_BUFFER = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dlsap_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dlsap_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [17:0]        csr_data
);

   dlsap_pkg::csr_type csr_ff;
   logic               s1_valid_ff, s1_valid_in;
   dlsap_pkg::req_type s1_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   dlsap_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               advance;
   logic               load;
   dlsap_pkg::tim_type tim;
   logic [2:0]         packet_kind;
   logic [2:0]         sample_count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.front_porch_lines    <= 11'd10;
         csr_ff.sync_lines           <= 11'd2;
         csr_ff.back_porch_lines     <= 11'd33;
         csr_ff.active_lines         <= 11'd480;
         csr_ff.blank_top            <= 11'd0;
         csr_ff.blank_bottom         <= 11'd0;
         csr_ff.mode_bits            <= 2'd0;
         csr_ff.samples_per_line_q16 <= 18'd0;
      end else if (csr_write) begin
         case (csr_index)
            dlsap_pkg::REG_FRONT_PORCH: csr_ff.front_porch_lines <= csr_data[10:0];
            dlsap_pkg::REG_SYNC:        csr_ff.sync_lines        <= csr_data[10:0];
            dlsap_pkg::REG_BACK_PORCH:  csr_ff.back_porch_lines  <= csr_data[10:0];
            dlsap_pkg::REG_ACTIVE:      csr_ff.active_lines      <= csr_data[10:0];
            dlsap_pkg::REG_BLANK_TOP:   csr_ff.blank_top         <= csr_data[10:0];
            dlsap_pkg::REG_BLANK_BOT:   csr_ff.blank_bottom      <= csr_data[10:0];
            dlsap_pkg::REG_MODE:        csr_ff.mode_bits         <= csr_data[1:0];
            dlsap_pkg::REG_SPL:         csr_ff.samples_per_line_q16 <= csr_data;
            default: ;
         endcase
      end
   end

   // Flow control between input register and result register.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign load      = req_valid && !req_stall;

   assign s1_valid_in  = load || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (load) begin
         s1_data_ff <= req_data;
      end
   end

   dlsap_timing #(
      .LINES_PER_BUFFER(LINES_PER_BUFFER)
   ) u_timing (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .csr             (csr_ff),
      .queue_nonempty  (s1_data_ff.queue_nonempty),
      .queue_head_line (s1_data_ff.queue_head_line),
      .tim             (tim)
   );

   dlsap_island u_island (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .csr               (csr_ff),
      .tim               (tim),
      .samples_available (s1_data_ff.samples_available),
      .packet_kind       (packet_kind),
      .sample_count      (sample_count)
   );

   // Assemble the line decision.
   always_comb begin
      rsp_data_in.line_phase     = tim.phase;
      rsp_data_in.line_index     = tim.line_index;
      rsp_data_in.blank_line     = tim.blank;
      rsp_data_in.take_buffer    = tim.take;
      rsp_data_in.use_buffer     = tim.use_buf;
      rsp_data_in.release_buffer = tim.release_buf;
      rsp_data_in.packet_kind    = packet_kind;
      rsp_data_in.sample_count   = sample_count;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/dlsap_checker.sv
// Port-level checks on the line sequencer, bound to the top level.
`include "dvi_line_sequencer_audio_pacer_core_assert.svh"

module dlsap_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input dlsap_pkg::rsp_type rsp_data
);

   // A stalled result stays in place.
   `DLSAP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Buffer activity and blanking only happen on active lines.
   `DLSAP_ASSERT_IMPL(a_idle_outside_active, rsp_valid && (rsp_data.line_phase != dlsap_pkg::PH_ACTIVE), !rsp_data.blank_line && !rsp_data.take_buffer && !rsp_data.use_buffer && !rsp_data.release_buffer)

   // A buffer taken or released is also the one feeding the line.
   `DLSAP_ASSERT_IMPL(a_take_rel_use, rsp_valid && (rsp_data.take_buffer || rsp_data.release_buffer), rsp_data.use_buffer)

   // Samples are counted only in audio sample packets, and never more than four.
   `DLSAP_ASSERT_IMPL(a_sample_kind, rsp_valid, (rsp_data.packet_kind == dlsap_pkg::PKT_SAMPLES) ? (rsp_data.sample_count != 3'd0 && rsp_data.sample_count <= dlsap_pkg::MAX_SAMPLES) : (rsp_data.sample_count == 3'd0))

endmodule

bind dvi_line_sequencer_audio_pacer_core dlsap_checker u_dlsap_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
